@@ src/bps_pkg.sv @@
// shared constants, codes and types of the binned peak score table
`timescale 1ns / 1ps

package bps_pkg;

   // table geometry
   localparam int NUM_CHROMOSOMES     = 20;
   localparam int BINS_PER_CHROMOSOME = 1024;
   localparam int TABLE_DEPTH         = NUM_CHROMOSOMES * BINS_PER_CHROMOSOME;
   localparam int ADDR_W              = $clog2(TABLE_DEPTH);
   localparam int BIN_W               = (BINS_PER_CHROMOSOME > 1) ?
                                        $clog2(BINS_PER_CHROMOSOME) : 1;

   // field widths
   localparam int CHR_W       = 5;
   localparam int POS_W       = 28;
   localparam int SCORE_W     = 16;
   localparam int BIDX_W      = 10;
   localparam int BIN_WIDTH_W = 28;
   localparam int SEL_W       = 6;
   localparam int WIN_W       = 29;
   localparam int CSR_DATA_W  = 29;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 64;
   localparam int ENTRY_W     = SCORE_W + POS_W;
   localparam int PROD_W      = BIN_W + 1 + BIN_WIDTH_W;
   localparam int DIV_CNT_W   = $clog2(POS_W + 1);

   // span of positions covered by the table
   localparam longint GENOME_SPAN = 200000000;

   // register reset values
   localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RESET = BIN_WIDTH_W'(1000000);
   localparam logic [SEL_W-1:0]       SEL_NONE        = {SEL_W{1'b1}};
   localparam logic [WIN_W-1:0]       WIN_NONE        = {WIN_W{1'b1}};

   // operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_WIDTH = 2'd0,
      CSR_CHR_SEL   = 2'd1,
      CSR_WIN_START = 2'd2,
      CSR_WIN_STOP  = 2'd3
   } csr_index_type;

   // table memory access
   typedef struct packed {
      logic               write;
      logic [ADDR_W-1:0]  waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [ADDR_W-1:0]  raddr;
   } mem_req_type;

endpackage

@@ src/bps_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bps_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bps_pkg::POS_W-1:0]           dividend,
   input  logic [bps_pkg::BIN_WIDTH_W-1:0]     divisor,
   output logic                                done,
   output logic [bps_pkg::POS_W-1:0]           quotient
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [bps_pkg::POS_W:0]           rem_ff;
   logic [bps_pkg::POS_W-1:0]         quo_ff;
   logic [bps_pkg::BIN_WIDTH_W-1:0]   dsr_ff;
   logic [bps_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [bps_pkg::POS_W:0]           rem_shift;
   logic [bps_pkg::POS_W:0]           rem_sub;
   logic                              fits;

   // trial subtract of the shifted remainder
   always_comb begin
      rem_shift = {rem_ff[bps_pkg::POS_W-1:0], quo_ff[bps_pkg::POS_W-1]};
      rem_sub   = rem_shift - (bps_pkg::POS_W + 1)'(dsr_ff);
      fits      = rem_shift >= (bps_pkg::POS_W + 1)'(dsr_ff);
   end

   // iteration control and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
            cnt_ff  <= bps_pkg::DIV_CNT_W'(bps_pkg::POS_W);
         end else if (busy_ff) begin
            rem_ff <= fits ? rem_sub : rem_shift;
            quo_ff <= {quo_ff[bps_pkg::POS_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == bps_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/bps_mem.sv @@
// peak table memory, one write and one registered read port
`timescale 1ns / 1ps

module bps_mem (
   input  logic                              clock,
   input  bps_pkg::mem_req_type              mem_req,
   output logic [bps_pkg::ENTRY_W-1:0]       rdata
);

   logic [bps_pkg::ENTRY_W-1:0] mem [bps_pkg::TABLE_DEPTH];
   logic [bps_pkg::ENTRY_W-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (mem_req.write) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/binned_peak_score_table.sv @@
// top level of the binned peak score table
//
//  channel | direction | handshake            | contents
//  req     | in        | req_tvalid/tready    | tdata chromosome..bin_index, tuser operation
//  rsp     | out       | rsp_tvalid/tready    | tdata bin_chromosome..occupied
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// a record goes through accept, the divider steps for position / bin_width, one multiply
// for the table limit, one compare, one memory read and a write back of a higher score
// a read goes through accept, memory read and the response register to its response
// one item at a time; the next request is taken once the sequencer is back in idle
// after reset the whole memory is cleared one entry a cycle, no requests taken
// a waiting response holds only a read in its last state; csr writes are always taken
`timescale 1ns / 1ps

module binned_peak_score_table (
   input  logic                                clock,
   input  logic                                reset,
   // chromosome, position, score, bin_index, zero padding
   input  logic [bps_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bin_chromosome, bin_number, peak_position, peak_score, occupied, zero padding
   output logic [bps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [bps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_CHECK,
      ST_WRITE,
      ST_RD_READ,
      ST_RD_RESP
   } state_type;

   state_type                          state_ff;
   logic [bps_pkg::ADDR_W-1:0]         clear_ff;
   logic [bps_pkg::BIN_WIDTH_W-1:0]    bin_width_ff;
   logic [bps_pkg::SEL_W-1:0]          chr_sel_ff;
   logic signed [bps_pkg::WIN_W-1:0]   win_start_ff;
   logic signed [bps_pkg::WIN_W-1:0]   win_stop_ff;
   logic [bps_pkg::CHR_W-1:0]          chr_ff;
   logic [bps_pkg::POS_W-1:0]          pos_ff;
   logic [bps_pkg::SCORE_W-1:0]        score_ff;
   logic [bps_pkg::BIDX_W-1:0]         bidx_ff;
   logic                               rd_ok_ff;
   logic [bps_pkg::BIN_W-1:0]          bin_ff;
   logic [bps_pkg::ADDR_W-1:0]         addr_ff;
   logic [bps_pkg::PROD_W-1:0]         prod_ff;
   logic [bps_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic                               rsp_valid_ff;

   logic [bps_pkg::CHR_W-1:0]          in_chr;
   logic [bps_pkg::POS_W-1:0]          in_pos;
   logic [bps_pkg::SCORE_W-1:0]        in_score;
   logic [bps_pkg::BIDX_W-1:0]         in_bidx;
   logic                               in_chr_ok;
   logic                               rec_drop;
   logic                               accept;
   logic                               div_start;
   logic                               div_done;
   logic [bps_pkg::POS_W-1:0]          quotient;
   logic [bps_pkg::ADDR_W-1:0]         chr_base;
   logic [bps_pkg::ADDR_W-1:0]         in_chr_base;
   bps_pkg::mem_req_type               mem_req;
   logic [bps_pkg::ENTRY_W-1:0]        mem_rdata;
   logic [bps_pkg::SCORE_W-1:0]        old_score;
   logic [bps_pkg::POS_W-1:0]          old_pos;
   logic                               rsp_free;

   // request fields
   assign in_chr   = req_tdata[4:0];
   assign in_pos   = req_tdata[32:5];
   assign in_score = req_tdata[48:33];
   assign in_bidx  = req_tdata[58:49];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // record filter on chromosome, window and bin width
   always_comb begin
      in_chr_ok = (in_chr >= bps_pkg::CHR_W'(1)) &&
                  (32'(in_chr) <= 32'(bps_pkg::NUM_CHROMOSOMES));
      rec_drop  = !in_chr_ok || (bin_width_ff == '0) ||
                  ((chr_sel_ff != bps_pkg::SEL_NONE) &&
                   ({2'b00, in_chr} != {chr_sel_ff[bps_pkg::SEL_W-1], chr_sel_ff})) ||
                  ((win_start_ff != $signed(bps_pkg::WIN_NONE)) &&
                   ($signed({1'b0, in_pos}) < win_start_ff)) ||
                  ((win_stop_ff != $signed(bps_pkg::WIN_NONE)) &&
                   ($signed({1'b0, in_pos}) > win_stop_ff));
      div_start = accept && (req_tuser == bps_pkg::OP_RECORD) && !rec_drop;
   end

   // base address of a chromosome's row of bins
   assign chr_base    = bps_pkg::ADDR_W'(32'(chr_ff - 1'b1) *
                                         32'(bps_pkg::BINS_PER_CHROMOSOME));
   assign in_chr_base = bps_pkg::ADDR_W'(32'(in_chr - 1'b1) *
                                         32'(bps_pkg::BINS_PER_CHROMOSOME));

   // stored entry
   assign old_score = mem_rdata[bps_pkg::SCORE_W-1:0];
   assign old_pos   = mem_rdata[bps_pkg::ENTRY_W-1:bps_pkg::SCORE_W];

   // memory access: clearing sweep or read-modify-write
   always_comb begin
      mem_req.raddr = addr_ff;
      if (state_ff == ST_CLEAR) begin
         mem_req.write = 1'b1;
         mem_req.waddr = clear_ff;
         mem_req.wdata = '0;
      end else begin
         mem_req.write = (state_ff == ST_WRITE) && (score_ff > old_score);
         mem_req.waddr = addr_ff;
         mem_req.wdata = {pos_ff, score_ff};
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= bps_pkg::BIN_WIDTH_RESET;
         chr_sel_ff   <= bps_pkg::SEL_NONE;
         win_start_ff <= $signed(bps_pkg::WIN_NONE);
         win_stop_ff  <= $signed(bps_pkg::WIN_NONE);
      end else if (csr_valid && csr_ready) begin
         unique case (bps_pkg::csr_index_type'(csr_index))
            bps_pkg::CSR_BIN_WIDTH: bin_width_ff <= csr_data[bps_pkg::BIN_WIDTH_W-1:0];
            bps_pkg::CSR_CHR_SEL:   chr_sel_ff   <= csr_data[bps_pkg::SEL_W-1:0];
            bps_pkg::CSR_WIN_START: win_start_ff <= $signed(csr_data[bps_pkg::WIN_W-1:0]);
            bps_pkg::CSR_WIN_STOP:  win_stop_ff  <= $signed(csr_data[bps_pkg::WIN_W-1:0]);
            default: ;
         endcase
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response taken; a new one from the last read state replaces it
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_RD_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clear_ff <= clear_ff + 1'b1;
               if (32'(clear_ff) == 32'(bps_pkg::TABLE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  chr_ff   <= in_chr;
                  pos_ff   <= in_pos;
                  score_ff <= in_score;
                  bidx_ff  <= in_bidx;
                  if (req_tuser == bps_pkg::OP_READ) begin
                     rd_ok_ff <= in_chr_ok &&
                                 (32'(in_bidx) < 32'(bps_pkg::BINS_PER_CHROMOSOME));
                     addr_ff  <= in_chr_base + bps_pkg::ADDR_W'(in_bidx);
                     state_ff <= ST_RD_READ;
                  end else if (!rec_drop) begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  bin_ff  <= quotient[bps_pkg::BIN_W-1:0];
                  addr_ff <= chr_base + bps_pkg::ADDR_W'(quotient[bps_pkg::BIN_W-1:0]);
                  if (32'(quotient) < 32'(bps_pkg::BINS_PER_CHROMOSOME)) begin
                     state_ff <= ST_MUL;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_MUL: begin
               // bin below span / bin_width exactly when (bin + 1) * bin_width <= span
               prod_ff  <= bps_pkg::PROD_W'({1'b0, bin_ff} + 1'b1) *
                           bps_pkg::PROD_W'(bin_width_ff);
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (prod_ff <= bps_pkg::PROD_W'(bps_pkg::GENOME_SPAN)) begin
                  state_ff <= ST_WRITE;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WRITE: begin
               state_ff <= ST_IDLE;
            end
            ST_RD_READ: begin
               state_ff <= ST_RD_RESP;
            end
            ST_RD_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'b0000,
                                   rd_ok_ff && (old_score != '0),
                                   rd_ok_ff ? old_score : bps_pkg::SCORE_W'(0),
                                   rd_ok_ff ? old_pos : bps_pkg::POS_W'(0),
                                   bidx_ff,
                                   chr_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   bps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (in_pos),
      .divisor  (bin_width_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   bps_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

endmodule

@@ src/bps_checker.sv @@
// port checker for the binned peak score table and its bind
`timescale 1ns / 1ps

module bps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tuser,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [bps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // occupied flag matches the peak score
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[59] == (rsp_tdata[58:43] != 16'd0)))
      else $error("occupied flag wrong");

   // one request at a time: busy right after a read request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bps_pkg::OP_READ) |=> !req_tready)
      else $error("request taken while busy");

   // a request taken with no response pending gives no response before the table is read
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response too early");

endmodule

bind binned_peak_score_table bps_checker u_bps_checker (.*);
